// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the humidity sensor reader.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition implies property in the same cycle.
`define ASSERT_IMPLY(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("assertion failed");
// Condition implies property in the following cycle.
`define ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ck, rn, cond, prop)
`define ASSERT_NEXT(label, ck, rn, cond, prop)
`endif
`endif

// ----- rtl/shw_pkg.sv -----
// Shared types and constants for the single-wire humidity sensor reader.
package shw_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = 8 * FRAME_BYTES;
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS);

    // Counter and configuration widths.
    localparam int TICK_W     = 10;
    localparam int TSU_W      = 19;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LOW_TO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_HIGH_TO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL  = 3'd6;

    // Error codes.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_RESP_LOW  = 2'd1;
    localparam logic [1:0] ERR_RESP_HIGH = 2'd2;
    localparam logic [1:0] ERR_BIT       = 2'd3;

    // Exchange phases.
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_START_HIGH = 3'd2,
        PH_RESP_LOW   = 3'd3,
        PH_RESP_HIGH  = 3'd4,
        PH_BIT_LOW    = 3'd5,
        PH_BIT_HIGH   = 3'd6
    } phase_t;

    // Configuration register set.
    typedef struct packed {
        logic [TICK_W-1:0] start_low_ticks;
        logic [7:0]        start_high_ticks;
        logic [7:0]        response_timeout_ticks;
        logic [7:0]        bit_low_timeout;
        logic [7:0]        bit_high_timeout;
        logic [7:0]        one_threshold;
        logic [TSU_W-1:0]  min_interval_ticks;
    } cfg_t;

    // One result of a sample tick.
    typedef struct packed {
        logic        drive_enable;
        logic        drive_level;
        logic        busy_res;
        logic        done_res;
        logic        fresh;
        logic [15:0] humidity;
        logic [15:0] temperature;
        logic        checksum_ok;
        logic [1:0]  error_code;
    } res_t;

endpackage

// ----- rtl/shw_cfg.sv -----
// Configuration register file of the humidity sensor reader.
module shw_cfg
    import shw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index of a write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_START_LOW:     cfg_next.start_low_ticks        = cfg_data[TICK_W-1:0];
                REG_START_HIGH:    cfg_next.start_high_ticks       = cfg_data[7:0];
                REG_RESP_TIMEOUT:  cfg_next.response_timeout_ticks = cfg_data[7:0];
                REG_BIT_LOW_TO:    cfg_next.bit_low_timeout        = cfg_data[7:0];
                REG_BIT_HIGH_TO:   cfg_next.bit_high_timeout       = cfg_data[7:0];
                REG_ONE_THRESHOLD: cfg_next.one_threshold          = cfg_data[7:0];
                REG_MIN_INTERVAL:  cfg_next.min_interval_ticks     = cfg_data[TSU_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register set with its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks        <= TICK_W'(180);
            cfg_reg.start_high_ticks       <= 8'd7;
            cfg_reg.response_timeout_ticks <= 8'd20;
            cfg_reg.bit_low_timeout        <= 8'd12;
            cfg_reg.bit_high_timeout       <= 8'd20;
            cfg_reg.one_threshold          <= 8'd8;
            cfg_reg.min_interval_ticks     <= TSU_W'(400000);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/shw_core.sv -----
// Exchange state machine, bit timing and frame decode for one sample tick.
module shw_core
    import shw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic tick_valid,
    input  logic start_request,
    input  logic line_level,
    input  cfg_t cfg,
    output res_t res
);

    localparam logic [TSU_W-1:0]  TSU_MAX  = {TSU_W{1'b1}};
    localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(1);

    phase_t                  phase_reg, phase_next;
    logic [TICK_W-1:0]       ticks_reg, ticks_next;
    logic [BIT_IDX_W-1:0]    bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [15:0]             humidity_reg, humidity_next;
    logic [15:0]             temperature_reg, temperature_next;
    logic                    meas_valid_reg, meas_valid_next;
    logic [TSU_W-1:0]        tsu_reg, tsu_next;
    logic                    checksum_reg, checksum_next;
    logic [1:0]              error_reg, error_next;

    logic [TICK_W-1:0]       ticks_inc;
    logic [TSU_W-1:0]        tsu_inc;
    logic [FRAME_BITS-1:0]   frame_shifted;
    logic                    bit_value;
    logic [15:0]             dec_humidity;
    logic [15:0]             dec_temperature;
    logic                    dec_checksum;
    logic                    done;
    logic                    fresh;

    // Byte i of a frame, first received byte at index 0; beyond the frame reads zero.
    function automatic logic [7:0] frame_byte(input logic [FRAME_BITS-1:0] frame,
                                              input int idx);
        logic [7:0] value;
        value = 8'h00;
        for (int j = 0; j < FRAME_BYTES; j++)
        begin
            if (j == idx)
            begin
                value = frame[8*(FRAME_BYTES-1-j) +: 8];
            end
        end
        return value;
    endfunction

    // Shared increments and the frame with the current bit shifted in.
    assign ticks_inc     = ticks_reg + TICK_ONE;
    assign tsu_inc       = (tsu_reg != TSU_MAX) ? tsu_reg + TSU_W'(1) : tsu_reg;
    assign bit_value     = (ticks_reg > {2'b00, cfg.one_threshold});
    assign frame_shifted = {frame_reg[FRAME_BITS-2:0], bit_value};

    // Decode of a completed frame: byte sum, humidity and sign-magnitude temperature.
    always_comb
    begin
        logic [7:0]  sum;
        logic [7:0]  b2;
        logic [15:0] mag;
        sum = 8'h00;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
        begin
            sum = sum + frame_byte(frame_shifted, i);
        end
        dec_checksum = (sum == frame_byte(frame_shifted, FRAME_BYTES - 1));
        dec_humidity = {frame_byte(frame_shifted, 0), frame_byte(frame_shifted, 1)};
        b2           = frame_byte(frame_shifted, 2);
        mag          = {1'b0, b2[6:0], frame_byte(frame_shifted, 3)};
        dec_temperature = b2[7] ? (16'h0000 - mag) : mag;
    end

    // Next state of the exchange and the result of this tick.
    always_comb
    begin
        phase_next       = phase_reg;
        ticks_next       = ticks_reg;
        bit_index_next   = bit_index_reg;
        frame_next       = frame_reg;
        humidity_next    = humidity_reg;
        temperature_next = temperature_reg;
        meas_valid_next  = meas_valid_reg;
        tsu_next         = tsu_inc;
        checksum_next    = checksum_reg;
        error_next       = error_reg;
        done             = 1'b0;
        fresh            = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start_request)
                begin
                    if (meas_valid_reg && (tsu_inc <= cfg.min_interval_ticks))
                    begin
                        // Reading is recent enough: return the cached values.
                        done       = 1'b1;
                        error_next = ERR_NONE;
                    end
                    else
                    begin
                        phase_next     = PH_START_LOW;
                        ticks_next     = TICK_ONE;
                        bit_index_next = '0;
                        frame_next     = '0;
                    end
                end
            end
            PH_START_LOW:
            begin
                if (ticks_reg >= cfg.start_low_ticks)
                begin
                    phase_next = PH_START_HIGH;
                    ticks_next = TICK_ONE;
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
            PH_START_HIGH:
            begin
                if (ticks_reg >= {2'b00, cfg.start_high_ticks})
                begin
                    phase_next = PH_RESP_LOW;
                    ticks_next = '0;
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
            PH_RESP_LOW:
            begin
                if (line_level)
                begin
                    // The rising sample is the first tick of the high response.
                    phase_next = PH_RESP_HIGH;
                    ticks_next = TICK_ONE;
                    if (TICK_ONE >= {2'b00, cfg.response_timeout_ticks})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_RESP_HIGH;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= {2'b00, cfg.response_timeout_ticks})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_RESP_LOW;
                        done       = 1'b1;
                    end
                end
            end
            PH_RESP_HIGH:
            begin
                if (!line_level)
                begin
                    // The falling sample is the first low tick of the first bit.
                    phase_next = PH_BIT_LOW;
                    ticks_next = TICK_ONE;
                    if (TICK_ONE > {2'b00, cfg.bit_low_timeout})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_BIT;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= {2'b00, cfg.response_timeout_ticks})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_RESP_HIGH;
                        done       = 1'b1;
                    end
                end
            end
            PH_BIT_LOW:
            begin
                if (line_level)
                begin
                    phase_next = PH_BIT_HIGH;
                    ticks_next = TICK_ONE;
                    if (TICK_ONE > {2'b00, cfg.bit_high_timeout})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_BIT;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > {2'b00, cfg.bit_low_timeout})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_BIT;
                        done       = 1'b1;
                    end
                end
            end
            PH_BIT_HIGH:
            begin
                if (line_level)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc > {2'b00, cfg.bit_high_timeout})
                    begin
                        phase_next = PH_IDLE;
                        error_next = ERR_BIT;
                        done       = 1'b1;
                    end
                end
                else
                begin
                    // Falling edge ends the bit: its high width sets the value.
                    frame_next = frame_shifted;
                    if (bit_index_reg >= BIT_IDX_W'(FRAME_BITS - 1))
                    begin
                        humidity_next    = dec_humidity;
                        temperature_next = dec_temperature;
                        checksum_next    = dec_checksum;
                        meas_valid_next  = 1'b1;
                        tsu_next         = '0;
                        error_next       = ERR_NONE;
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                        fresh            = 1'b1;
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + BIT_IDX_W'(1);
                        phase_next     = PH_BIT_LOW;
                        ticks_next     = TICK_ONE;
                        if (TICK_ONE > {2'b00, cfg.bit_low_timeout})
                        begin
                            phase_next = PH_IDLE;
                            error_next = ERR_BIT;
                            done       = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                ticks_next = '0;
            end
        endcase

        // Wire drive follows the phase after this tick.
        case (phase_next)
            PH_IDLE, PH_START_HIGH:
            begin
                res.drive_enable = 1'b1;
                res.drive_level  = 1'b1;
            end
            PH_START_LOW:
            begin
                res.drive_enable = 1'b1;
                res.drive_level  = 1'b0;
            end
            default:
            begin
                res.drive_enable = 1'b0;
                res.drive_level  = 1'b0;
            end
        endcase
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = done;
        res.fresh       = fresh;
        res.humidity    = humidity_next;
        res.temperature = temperature_next;
        res.checksum_ok = checksum_next;
        res.error_code  = error_next;
    end

    // State registers advance once per processed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            ticks_reg       <= '0;
            bit_index_reg   <= '0;
            frame_reg       <= '0;
            humidity_reg    <= '0;
            temperature_reg <= '0;
            meas_valid_reg  <= 1'b0;
            tsu_reg         <= '0;
            checksum_reg    <= 1'b0;
            error_reg       <= ERR_NONE;
        end
        else if (tick_valid)
        begin
            phase_reg       <= phase_next;
            ticks_reg       <= ticks_next;
            bit_index_reg   <= bit_index_next;
            frame_reg       <= frame_next;
            humidity_reg    <= humidity_next;
            temperature_reg <= temperature_next;
            meas_valid_reg  <= meas_valid_next;
            tsu_reg         <= tsu_next;
            checksum_reg    <= checksum_next;
            error_reg       <= error_next;
        end
    end

endmodule

// ----- rtl/shw_obuf.sv -----
// Two-entry output buffer that holds results while the output side stalls.
module shw_obuf
    import shw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic head_valid,
    output res_t head_data,
    input  logic out_stall
);

    logic head_valid_reg, head_valid_next;
    logic spare_valid_reg, spare_valid_next;
    res_t head_reg, head_next;
    res_t spare_reg, spare_next;
    logic pop;

    assign pop  = head_valid_reg && !out_stall;
    assign full = head_valid_reg && spare_valid_reg;

    // Move results between the head and the spare entry.
    always_comb
    begin
        head_valid_next  = head_valid_reg;
        spare_valid_next = spare_valid_reg;
        head_next        = head_reg;
        spare_next       = spare_reg;
        if (pop)
        begin
            head_next        = spare_reg;
            head_valid_next  = spare_valid_reg;
            spare_valid_next = 1'b0;
        end
        if (push && !full)
        begin
            if (!head_valid_next)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                spare_next       = push_data;
                spare_valid_next = 1'b1;
            end
        end
    end

    // Valid flags are reset; the result payload needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg  <= head_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        spare_reg <= spare_next;
    end

    assign head_valid = head_valid_reg;
    assign head_data  = head_reg;

endmodule

// ----- rtl/single_wire_humidity_sensor_reader_top.sv -----
// Path: an accepted request is held in the input register, then processed by the
// state machine as it is pushed into the output buffer, whose head is offered.
// Throughput: one sample tick per cycle while the output buffer has room.
// Output stalls are absorbed by a two-entry buffer before the input stalls.
// Reset: asynchronous, active low; state machine idle, cached reading invalid,
// configuration registers at their default values, no result pending.
`include "assert_macros.svh"

module single_wire_humidity_sensor_reader_top
    import shw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  start_request,
    input  logic                  line_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  drive_enable,
    output logic                  drive_level,
    output logic                  busy_res,
    output logic                  done_res,
    output logic                  fresh,
    output logic [15:0]           humidity,
    output logic signed [15:0]    temperature,
    output logic                  checksum_ok,
    output logic [1:0]            error_code,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t core_res;
    res_t head_data;
    logic obuf_full;
    logic in_accept;
    logic s1_advance;
    logic s1_valid_reg, s1_valid_next;
    logic s1_req_reg;
    logic s1_line_reg;

    shw_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Input register: holds one request until the output buffer has room.
    assign in_stall   = s1_valid_reg && obuf_full;
    assign in_accept  = in_valid && !in_stall;
    assign s1_advance = s1_valid_reg && !obuf_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_req_reg  <= start_request;
            s1_line_reg <= line_level;
        end
    end

    shw_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (s1_advance),
        .start_request (s1_req_reg),
        .line_level    (s1_line_reg),
        .cfg           (cfg),
        .res           (core_res)
    );

    shw_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s1_advance),
        .push_data  (core_res),
        .full       (obuf_full),
        .head_valid (out_valid),
        .head_data  (head_data),
        .out_stall  (out_stall)
    );

    // Result fields on their own ports.
    assign drive_enable = head_data.drive_enable;
    assign drive_level  = head_data.drive_level;
    assign busy_res     = head_data.busy_res;
    assign done_res     = head_data.done_res;
    assign fresh        = head_data.fresh;
    assign humidity     = head_data.humidity;
    assign temperature  = head_data.temperature;
    assign checksum_ok  = head_data.checksum_ok;
    assign error_code   = head_data.error_code;

    // Design checks.
    `ASSERT_IMPLY(a_stall_means_pending, clk, rst_n, in_stall, out_valid)
    `ASSERT_NEXT(a_accept_loads_input, clk, rst_n, in_accept, s1_valid_reg)
    `ASSERT_IMPLY(a_fresh_has_no_error, clk, rst_n, out_valid && fresh, done_res && (error_code == ERR_NONE) && !busy_res)
    `ASSERT_IMPLY(a_released_low, clk, rst_n, out_valid && !drive_enable, !drive_level && busy_res)

endmodule
